### sv/lrac_pkg.sv
// shared types, constants and helpers for the lattice reaction attempt core
`timescale 1ns / 1ps
`default_nettype none

package lrac_pkg;

   localparam int GRID_WIDTH     = 256;
   localparam int GRID_HEIGHT    = 256;
   localparam int REACTION_SLOTS = 8;
   localparam int SPECIES_BITS   = 2;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_BITS  = 20;
   localparam int SLOT_IDX_BITS = 3;
   localparam int X_BITS     = $clog2(GRID_WIDTH);
   localparam int Y_BITS     = $clog2(GRID_HEIGHT);
   localparam int ADDR_BITS  = X_BITS + Y_BITS;
   localparam int RATE_BITS  = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [RATE_BITS-1:0] RATE_ONE = 16'h0100;
   localparam logic [1:0] SPECIES_MASK = 2'((1 << SPECIES_BITS) - 1);

   localparam logic [SLOT_BITS-1:0] SLOT_RESET [SLOT_COUNT] = '{
      20'h10400, 20'h40003, 20'h60A00, 20'h80100,
      20'hB2700, 20'hC0100, 20'h00000, 20'h00000
   };

   // item kinds
   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_ATTEMPT = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;

   // neighbour directions
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  cell_x;
      logic [7:0]  cell_y;
      logic [1:0]  neighbour_dir;
      logic [2:0]  reaction_index;
      logic [15:0] chance;
      logic [1:0]  load_value;
   } req_type;

   typedef struct packed {
      logic [1:0] cell_state;
      logic       changed;
      logic       reaction_done;
   } rsp_type;

   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] addr;
      logic [1:0]           wdata;
   } ram_req_type;

   typedef struct packed {
      logic                 accept;
      logic                 last;
      logic [RATE_BITS-1:0] next_rate;
   } rate_res_type;

   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [X_BITS-1:0] x,
                                                      input logic [Y_BITS-1:0] y);
      cell_addr = {y, x};
   endfunction

endpackage

`default_nettype wire

### sv/lattice_reaction_attempt_core.sv
// top level of the lattice reaction attempt core
//
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_type (kind, cell, dir, slot, chance, load)
// rsp       out        rsp_valid/rsp_stall  rsp_type (cell_state, changed, reaction_done)
// csr       in/out     psel/penable/pready  20-bit reaction slots at paddr 4*i
//
// a load steps write, emit; a read steps read, emit; an attempt steps cell, dec, emit
// the result is registered from the write, read or dec state, and into the output register on emit
// the single-port grid memory sets the attempt order: neighbour read, cell read, then write-back
// one item at a time; req_stall drops as the result is registered, and the next item may follow
// a result held by rsp_stall does not block the next item, only the one after it
// reset is synchronous; slots return to their defaults, the grid is not cleared
`timescale 1ns / 1ps
`default_nettype none

module lattice_reaction_attempt_core
   import lrac_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_data,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   logic [SLOT_BITS-1:0] slot_rd;
   ram_req_type          ram_req;
   logic [1:0]           ram_rdata;
   logic [RATE_BITS-1:0] rate_q;
   logic [15:0]          chance_q;
   rate_res_type         rate_res;

   lrac_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .slot_idx (req_data.reaction_index),
      .slot_rd  (slot_rd)
   );

   lrac_grid_ram #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (2)
   ) u_grid (
      .clock (clock),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

   lrac_rate_unit u_rate (
      .rate   (rate_q),
      .chance (chance_q),
      .res    (rate_res)
   );

   lrac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .slot_rd   (slot_rd),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .rate_q    (rate_q),
      .chance_q  (chance_q),
      .rate_res  (rate_res)
   );

endmodule

`default_nettype wire

### sv/lrac_grid_ram.sv
// single-port species grid memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module lrac_grid_ram #(
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 2
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] addr,
   input  wire logic [DATA_BITS-1:0] wdata,
   output logic      [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### sv/lrac_csr.sv
// reaction slot registers behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module lrac_csr
   import lrac_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   input  wire logic [SLOT_IDX_BITS-1:0] slot_idx,
   output logic      [SLOT_BITS-1:0]     slot_rd
);

   logic [SLOT_BITS-1:0]     slot_ff [SLOT_COUNT];
   logic [CSR_DATA_BITS-1:0] prdata_ff;
   logic [SLOT_BITS-1:0]     slot_rd_ff;
   logic                     wr_en;
   logic [SLOT_IDX_BITS-1:0] wr_idx;

   assign wr_en  = psel & penable & pwrite;
   assign wr_idx = paddr[CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_ff[i] <= SLOT_RESET[i];
         end
      end else if (wr_en) begin
         slot_ff[wr_idx] <= pwdata[SLOT_BITS-1:0];
      end
   end

   // both read ports registered; address is stable from the setup cycle
   always_ff @(posedge clock) begin
      prdata_ff <= CSR_DATA_BITS'(slot_ff[wr_idx]);
      if ({1'b0, slot_idx} < (SLOT_IDX_BITS + 1)'(REACTION_SLOTS)) begin
         slot_rd_ff <= slot_ff[slot_idx];
      end else begin
         slot_rd_ff <= '0;
      end
   end

   assign prdata  = prdata_ff;
   assign pready  = 1'b1;
   assign slot_rd = slot_rd_ff;

endmodule

`default_nettype wire

### sv/lrac_rate_unit.sv
// remaining-rate compare and decrement unit
`timescale 1ns / 1ps
`default_nettype none

module lrac_rate_unit
   import lrac_pkg::*;
(
   input  wire logic [RATE_BITS-1:0] rate,
   input  wire logic [15:0]          chance,
   output rate_res_type              res
);

   logic below_one;

   assign below_one = rate < RATE_ONE;

   always_comb begin
      // fractional rate scaled to the 16-bit draw
      res.accept    = !below_one || (chance <= {rate[7:0], 8'h00});
      res.last      = rate <= RATE_ONE;
      res.next_rate = res.last ? '0 : rate - RATE_ONE;
   end

endmodule

`default_nettype wire

### sv/lrac_ctrl.sv
// item sequencer: grid accesses, reaction latch and result register
`timescale 1ns / 1ps
`default_nettype none

module lrac_ctrl
   import lrac_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic [SLOT_BITS-1:0] slot_rd,
   output ram_req_type               ram_req,
   input  wire logic [1:0]           ram_rdata,
   output logic [RATE_BITS-1:0]      rate_q,
   output logic [15:0]               chance_q,
   input  wire rate_res_type         rate_res
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WRITE = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_CELL  = 3'd3;
   localparam logic [2:0] ST_DEC   = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [ADDR_BITS-1:0] here_ff;
   logic [1:0]           loadv_ff;
   logic [15:0]          chance_ff;
   logic [1:0]           nb_ff;
   logic [RATE_BITS-1:0] rate_ff, rate_in;
   logic                 busy_ff, busy_in;
   logic [1:0]           src_ff, src_in;
   logic [1:0]           sink_ff, sink_in;
   rsp_type              res_ff, res_in;
   rsp_type              out_ff;
   logic                 out_valid_ff, out_valid_in;

   logic [X_BITS-1:0]    req_x, nb_x;
   logic [Y_BITS-1:0]    req_y, nb_y;
   logic [ADDR_BITS-1:0] req_here, req_nb;
   logic                 req_acc;
   logic                 out_free;
   logic                 hit;

   assign req_x = X_BITS'(req_data.cell_x);
   assign req_y = Y_BITS'(req_data.cell_y);

   // wrapped neighbour on the torus
   always_comb begin
      nb_x = req_x;
      nb_y = req_y;
      case (req_data.neighbour_dir)
         DIR_UP: begin
            nb_y = (req_y == '0) ? Y_BITS'(GRID_HEIGHT - 1) : req_y - 1'b1;
         end
         DIR_RIGHT: begin
            nb_x = (req_x == X_BITS'(GRID_WIDTH - 1)) ? '0 : req_x + 1'b1;
         end
         DIR_DOWN: begin
            nb_y = (req_y == Y_BITS'(GRID_HEIGHT - 1)) ? '0 : req_y + 1'b1;
         end
         default: begin
            nb_x = (req_x == '0) ? X_BITS'(GRID_WIDTH - 1) : req_x - 1'b1;
         end
      endcase
   end

   assign req_here = cell_addr(req_x, req_y);
   assign req_nb   = cell_addr(nb_x, nb_y);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // death reaction ignores the neighbour
   assign hit = rate_res.accept && (ram_rdata == src_ff) &&
                ((sink_ff == 2'd0) || (nb_ff == sink_ff));

   always_comb begin
      ram_req.we    = 1'b0;
      ram_req.addr  = here_ff;
      ram_req.wdata = loadv_ff;
      state_in      = state_ff;
      rate_in       = rate_ff;
      busy_in       = busy_ff;
      src_in        = src_ff;
      sink_in       = sink_ff;
      res_in        = res_ff;
      out_valid_in  = out_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            // read issued on the accept edge: neighbour for attempts, cell otherwise
            ram_req.addr = (req_data.kind == KIND_ATTEMPT) ? req_nb : req_here;
            if (req_acc) begin
               case (req_data.kind)
                  KIND_LOAD:    state_in = ST_WRITE;
                  KIND_ATTEMPT: state_in = ST_CELL;
                  default:      state_in = ST_READ;
               endcase
            end
         end
         ST_WRITE: begin
            ram_req.we = 1'b1;
            res_in     = '{cell_state: loadv_ff, changed: 1'b0, reaction_done: 1'b0};
            state_in   = ST_EMIT;
         end
         ST_READ: begin
            res_in   = '{cell_state: ram_rdata, changed: 1'b0, reaction_done: 1'b0};
            state_in = ST_EMIT;
         end
         ST_CELL: begin
            if (!busy_ff) begin
               src_in  = slot_rd[19:18];
               sink_in = slot_rd[17:16];
               rate_in = slot_rd[15:0];
               busy_in = (slot_rd[15:0] != '0);
            end
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (!busy_ff) begin
               // zero rate: no attempt
               res_in = '{cell_state: ram_rdata, changed: 1'b0, reaction_done: 1'b1};
            end else begin
               ram_req.we    = hit;
               ram_req.wdata = sink_ff & SPECIES_MASK;
               res_in.cell_state    = hit ? (sink_ff & SPECIES_MASK) : ram_rdata;
               res_in.changed       = hit;
               res_in.reaction_done = rate_res.last;
               rate_in = rate_res.next_rate;
               busy_in = !rate_res.last;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= '0;
         busy_ff      <= 1'b0;
         src_ff       <= '0;
         sink_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         busy_ff      <= busy_in;
         src_ff       <= src_in;
         sink_ff      <= sink_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         here_ff   <= req_here;
         loadv_ff  <= req_data.load_value & SPECIES_MASK;
         chance_ff <= req_data.chance;
      end
      if (state_ff == ST_CELL) begin
         nb_ff <= ram_rdata;
      end
      res_ff <= res_in;
      if (state_ff == ST_EMIT && out_free) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign rate_q    = rate_ff;
   assign chance_q  = chance_ff;

endmodule

`default_nettype wire
